@@ rtl/cop_pkg.sv @@
// shared types and constants for the cylinder overlap pushout block
`timescale 1ns / 1ps
`default_nettype none
package cop_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CW = 32;
  localparam int RW = 30;
  localparam int RSW = 31;
  localparam int SW = 63;
  localparam int DW = 32;
  localparam int QW = 64;
  localparam int SQ_STEPS = 32;
  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic [RW-1:0] a_radius;
    logic [RW-1:0] a_height;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic [RW-1:0] b_radius;
    logic [RW-1:0] b_height;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic coincident;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/cop_if.sv @@
// valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
`default_nettype none
interface cop_in_if;
  logic valid;
  logic ready;
  cop_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cop_out_if;
  logic valid;
  logic ready;
  cop_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/cylinder_overlap_pushout.sv @@
// top level: overlap test, square root, divide and saturate pipeline
// throughput: one request per cycle unless the output stalls; the square root (32 stages) and the
// two 64-stage dividers set the depth
// the pipeline advances whenever its last stage is empty or taken
// reset (synchronous) clears all valid bits; payload is not reset
`timescale 1ns / 1ps
`default_nettype none
module cylinder_overlap_pushout (
  input wire logic clk,
  input wire logic rst,
  cop_in_if.sink in_ch,
  cop_out_if.source out_ch
);
  localparam int SQ = cop_pkg::SQ_STEPS;
  localparam int DV = cop_pkg::DIV_STEPS;
  localparam int LAT = 3 + SQ + 1 + DV + 3;

  logic en;
  logic [LAT-1:0] vld;
  assign en = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_ch.valid};
  end

  typedef struct packed {
    logic miss;
    logic coin;
    logic signed [31:0] ax;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic sx;
    logic sz;
    logic [32:0] mx;
    logic [32:0] mz;
    logic [cop_pkg::RSW-1:0] rng;
  } ctx_t;

  // stage 1: differences and vertical test
  cop_pkg::in_item_t d;
  ctx_t c1;
  logic signed [33:0] btop, atop;
  logic signed [32:0] dx, dz;
  assign d = in_ch.data;
  always_comb begin
    btop = 34'(d.b_y) + 34'($signed({1'b0, d.b_height}));
    atop = 34'(d.a_y) + 34'($signed({1'b0, d.a_height}));
    dx = 33'(d.b_x) - 33'(d.a_x);
    dz = 33'(d.b_z) - 33'(d.a_z);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1.miss <= (34'(d.a_y) > btop) || (atop < 34'(d.b_y));
      c1.coin <= 1'b0;
      c1.ax <= d.a_x; c1.az <= d.a_z;
      c1.bx <= d.b_x; c1.by <= d.b_y; c1.bz <= d.b_z;
      c1.sx <= dx[32]; c1.sz <= dz[32];
      c1.mx <= dx[32] ? 33'(-dx) : 33'(dx);
      c1.mz <= dz[32] ? 33'(-dz) : 33'(dz);
      c1.rng <= {1'b0, d.a_radius} + {1'b0, d.b_radius};
    end
  end

  // stage 2: coarse range check and squares
  ctx_t c2, c2_next;
  logic [63:0] qx, qz, rr;
  logic coarse;
  assign coarse = (c1.mx > 33'(c1.rng)) || (c1.mz > 33'(c1.rng));
  always_comb begin
    c2_next = c1;
    c2_next.miss = c1.miss || coarse;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c2_next;
      qx <= 64'(c1.mx[30:0]) * 64'(c1.mx[30:0]);
      qz <= 64'(c1.mz[30:0]) * 64'(c1.mz[30:0]);
      rr <= 64'(c1.rng) * 64'(c1.rng);
    end
  end

  // stage 3: sum and compare
  ctx_t c3, c3_next;
  logic [cop_pkg::SW-1:0] s3;
  logic [63:0] ssum;
  assign ssum = qx + qz;
  always_comb begin
    c3_next = c2;
    c3_next.miss = c2.miss || (ssum > rr);
    c3_next.coin = (ssum == 64'd0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c3_next;
      s3 <= cop_pkg::SW'(ssum);
    end
  end

  // context rides alongside the root stages
  logic [cop_pkg::DW-1:0] root;
  cop_sqrt u_sqrt (.clk(clk), .en(en), .s(s3), .root(root));

  ctx_t cq [SQ+1];
  assign cq[0] = c3;
  for (genvar i = 0; i < SQ; i++) begin : g_cq
    always_ff @(posedge clk) if (en) cq[i+1] <= cq[i];
  end

  // numerators: mag*range + floor(d/2), d forced nonzero
  ctx_t c5;
  logic [63:0] px, pz;
  logic [cop_pkg::DW-1:0] dd, dd5;
  assign dd = (root == '0) ? cop_pkg::DW'(1) : root;
  always_ff @(posedge clk) begin
    if (en) begin
      c5 <= cq[SQ];
      px <= 64'(cq[SQ].mx[30:0]) * 64'(cq[SQ].rng);
      pz <= 64'(cq[SQ].mz[30:0]) * 64'(cq[SQ].rng);
      dd5 <= dd;
    end
  end
  logic [63:0] nx, nz;
  assign nx = px + 64'(dd5 >> 1);
  assign nz = pz + 64'(dd5 >> 1);

  logic [63:0] qox, qoz;
  cop_div u_divx (.clk(clk), .en(en), .num(nx), .den(dd5), .quo(qox));
  cop_div u_divz (.clk(clk), .en(en), .num(nz), .den(dd5), .quo(qoz));

  ctx_t cd [DV+1];
  assign cd[0] = c5;
  for (genvar i = 0; i < DV; i++) begin : g_cd
    always_ff @(posedge clk) if (en) cd[i+1] <= cd[i];
  end

  // final: apply sign, add, saturate
  ctx_t cf;
  logic signed [34:0] ox, oz;
  always_ff @(posedge clk) begin
    if (en) begin
      cf <= cd[DV];
      ox <= cd[DV].sx ? -$signed({2'b0, qox[32:0]}) : $signed({2'b0, qox[32:0]});
      oz <= cd[DV].sz ? -$signed({2'b0, qoz[32:0]}) : $signed({2'b0, qoz[32:0]});
    end
  end
  logic signed [35:0] rx, rz;
  ctx_t cg;
  always_ff @(posedge clk) begin
    if (en) begin
      cg <= cf;
      rx <= 36'(cf.ax) + 36'(ox);
      rz <= 36'(cf.az) + 36'(oz);
    end
  end

  function automatic logic signed [31:0] sat(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  cop_pkg::out_item_t o;
  always_ff @(posedge clk) begin
    if (en) begin
      o.hit <= !cg.miss;
      o.coincident <= !cg.miss && cg.coin;
      o.out_y <= cg.by;
      if (cg.miss || cg.coin) begin
        o.out_x <= cg.bx;
        o.out_z <= cg.bz;
      end else begin
        o.out_x <= sat(rx);
        o.out_z <= sat(rz);
      end
    end
  end
  assign out_ch.valid = vld[LAT-1];
  assign out_ch.data = o;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_coin: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.coincident |-> out_ch.data.hit)
    else $error("coincident without hit");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("stalled with empty output");
`endif
endmodule
`default_nettype wire

@@ rtl/cop_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module cop_sqrt (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [cop_pkg::SW-1:0] s,
  output logic [cop_pkg::DW-1:0] root
);
  localparam int N = cop_pkg::SQ_STEPS;
  logic [cop_pkg::SW:0] rem [N+1];
  logic [cop_pkg::DW-1:0] r [N+1];

  always_comb begin
    rem[0] = {1'b0, s};
    r[0] = '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam int SH = 2 * (N - 1 - i);
    logic [cop_pkg::SW+2:0] trial;
    logic [cop_pkg::SW+2:0] cur;
    always_comb begin
      trial = ({3'b0, r[i]} << (SH + 2)) | ((cop_pkg::SW+3)'(1) << SH);
      cur = {2'b0, rem[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem[i+1] <= (cop_pkg::SW+1)'(cur - trial);
          r[i+1] <= {r[i][cop_pkg::DW-2:0], 1'b1};
        end else begin
          rem[i+1] <= rem[i];
          r[i+1] <= {r[i][cop_pkg::DW-2:0], 1'b0};
        end
      end
    end
  end
  assign root = r[N];
endmodule
`default_nettype wire

@@ rtl/cop_div.sv @@
// pipelined restoring divider for the two rounded push offsets
`timescale 1ns / 1ps
`default_nettype none
module cop_div (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [cop_pkg::QW-1:0] num,
  input  wire logic [cop_pkg::DW-1:0] den,
  output logic [cop_pkg::QW-1:0] quo
);
  localparam int N = cop_pkg::DIV_STEPS;
  logic [cop_pkg::DW:0] rem [N+1];
  logic [cop_pkg::QW-1:0] q [N+1];
  logic [cop_pkg::DW-1:0] dv [N+1];

  always_comb begin
    rem[0] = '0;
    q[0] = num;
    dv[0] = den;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [cop_pkg::DW+1:0] sh;
    always_comb sh = {rem[i], q[i][cop_pkg::QW-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= dv[i];
        if (sh >= {2'b0, dv[i]}) begin
          rem[i+1] <= (cop_pkg::DW+1)'(sh - {2'b0, dv[i]});
          q[i+1] <= {q[i][cop_pkg::QW-2:0], 1'b1};
        end else begin
          rem[i+1] <= sh[cop_pkg::DW:0];
          q[i+1] <= {q[i][cop_pkg::QW-2:0], 1'b0};
        end
      end
    end
  end
  assign quo = q[N];
endmodule
`default_nettype wire

@@ tb/cop_checker.sv @@
// checker: watches both channels, predicts each pushout result and compares
`timescale 1ns / 1ps
`default_nettype none
module cop_checker (
  input wire logic clk,
  input wire logic rst,
  cop_in_if.sink in_mon,
  cop_out_if.sink out_mon,
  output int errors,
  output int pending
);
  cop_pkg::out_item_t expected_q[$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint offset_along(input longint delta, input longint span,
                                          input longint root_d);
    logic [63:0] mag;
    logic [63:0] q;
    mag = delta < 0 ? -delta : delta;
    q = (mag * span + root_d / 2) / root_d;
    return delta < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic cop_pkg::out_item_t resolve_pair(input cop_pkg::in_item_t r);
    cop_pkg::out_item_t o;
    longint ax, ay, az, bx, by, bz, span, dx, dz, adx, adz;
    logic [63:0] s, d;
    ax = r.a_x; ay = r.a_y; az = r.a_z;
    bx = r.b_x; by = r.b_y; bz = r.b_z;
    span = longint'(r.a_radius) + longint'(r.b_radius);
    dx = bx - ax;
    dz = bz - az;
    adx = dx < 0 ? -dx : dx;
    adz = dz < 0 ? -dz : dz;
    o.hit = 1'b1;
    o.coincident = 1'b0;
    o.out_x = r.b_x;
    o.out_y = r.b_y;
    o.out_z = r.b_z;
    if (ay > by + longint'(r.b_height)) o.hit = 1'b0;
    else if (ay + longint'(r.a_height) < by) o.hit = 1'b0;
    else if (adx > span || adz > span) o.hit = 1'b0;
    else begin
      s = adx * adx + adz * adz;
      if (s > span * span) o.hit = 1'b0;
      else if (s == 0) o.coincident = 1'b1;
      else begin
        d = floor_sqrt(s);
        o.out_x = 32'(clamp32(ax + offset_along(dx, span, d)));
        o.out_z = 32'(clamp32(az + offset_along(dz, span, d)));
      end
    end
    return o;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    cop_pkg::out_item_t got;
    cop_pkg::out_item_t want;
    if (!rst) begin
      if (in_mon.valid && in_mon.ready) expected_q.push_back(resolve_pair(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit) report("hit", got.hit, want.hit);
          if (got.coincident !== want.coincident)
            report("coincident", got.coincident, want.coincident);
          if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
          if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
          if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
        end
      end
      pending = expected_q.size();
    end
  end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// testbench top: clock, reset, request stimulus, result back-pressure, verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst;
  int errors;
  int pending;
  int quiet;

  cop_in_if in_ch();
  cop_out_if out_ch();

  cylinder_overlap_pushout uut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  cop_checker chk (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
                   .errors(errors), .pending(pending));

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return $urandom();
    if (p == 1) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
  endfunction

  function automatic logic [29:0] rand_len();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 30'($urandom());
    if (p == 1) return $urandom_range(0, 1) ? 30'h3fff_ffff : 30'd0;
    return 30'($urandom_range(0, 32'h0020_0000));
  endfunction

  // mostly pairs placed near each other so hits and pushes dominate
  function automatic cop_pkg::in_item_t rand_pair();
    cop_pkg::in_item_t r;
    longint span;
    r.a_x = rand_coord(); r.a_y = rand_coord(); r.a_z = rand_coord();
    r.a_radius = rand_len(); r.a_height = rand_len();
    r.b_radius = rand_len(); r.b_height = rand_len();
    r.b_x = rand_coord(); r.b_y = rand_coord(); r.b_z = rand_coord();
    if ($urandom_range(0, 9) < 7) begin
      span = longint'(r.a_radius) + longint'(r.b_radius) + 2;
      r.b_x = 32'(r.a_x + (longint'($urandom()) % span));
      r.b_z = 32'(r.a_z + (longint'($urandom()) % span));
      r.b_y = 32'(r.a_y + (longint'($urandom()) % (longint'(r.a_height) + 2)));
      if ($urandom_range(0, 3) == 0) r.b_x = -r.b_x;
    end
    return r;
  endfunction

  function automatic cop_pkg::in_item_t make_pair(input int ax, ay, az, ar, ah,
                                                  input int bx, by, bz, br, bh);
    cop_pkg::in_item_t r;
    r.a_x = ax; r.a_y = ay; r.a_z = az; r.a_radius = 30'(ar); r.a_height = 30'(ah);
    r.b_x = bx; r.b_y = by; r.b_z = bz; r.b_radius = 30'(br); r.b_height = 30'(bh);
    return r;
  endfunction

  task automatic send_request(input cop_pkg::in_item_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.data <= r;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random result back-pressure, with calm stretches
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (($time / 20) % 3000 < 300) out_ch.ready <= 1'b1;
    else out_ch.ready <= (gap_len() == 0);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("cylinder_overlap_pushout test failed");
      $finish;
    end
  end

  initial begin
    cop_pkg::in_item_t directed[$];
    int k;
    quiet = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // miss above, miss below, vertical edge contact, radius-sum contact, near miss just beyond it
    directed.push_back(make_pair(0, 100, 0, 10, 5, 0, 0, 0, 10, 99));
    directed.push_back(make_pair(0, 0, 0, 10, 5, 3, 6, 0, 10, 5));
    directed.push_back(make_pair(0, 5, 0, 10, 5, 3, 0, 4, 10, 5));
    directed.push_back(make_pair(0, 0, 0, 3, 1, 3, 1, 4, 2, 1));
    directed.push_back(make_pair(0, 0, 0, 3, 1, 3, 0, 5, 2, 1));
    // coincident centres
    directed.push_back(make_pair(7, 0, -9, 5, 5, 7, 2, -9, 5, 5));
    // extreme coordinates and lengths
    directed.push_back(make_pair(32'h7fff_ffff, 0, 32'h7fff_ffff, 30'h3fff_ffff, 30'h3fff_ffff,
                                 32'h7fff_fff0, 0, 32'h7fff_fff0, 30'h3fff_ffff, 0));
    directed.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 30'h3fff_ffff,
                                 30'h3fff_ffff, 32'h8000_0010, 32'h8000_0000, 32'h8000_0000,
                                 30'h3fff_ffff, 30'h3fff_ffff));
    directed.push_back(make_pair(32'h8000_0000, 0, 0, 30'h3fff_ffff, 0,
                                 32'h7fff_ffff, 0, 0, 30'h3fff_ffff, 0));
    directed.push_back(make_pair(0, 32'h7fff_ffff, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 30'h3fff_ffff));
    directed.push_back(make_pair(-1, -1, -1, 1, 1, 0, -1, 0, 1, 0));
    directed.push_back(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(make_pair(100, 0, 200, 1000, 0, 101, 0, 199, 0, 0));
    foreach (directed[i]) send_request(directed[i]);
    in_ch.valid <= 1'b0;
    // hold off until the pipeline has drained
    while (pending != 0) @(negedge clk);
    for (k = 0; k < 2000; k++) send_request(rand_pair());
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (errors == 0) $display("cylinder_overlap_pushout test passed");
    else $display("cylinder_overlap_pushout test failed");
    $finish;
  end
endmodule
`default_nettype wire
